### hdl/assert_macros.svh
// Assertion helpers for the RTL files that check their own behavior; the tracker top includes them.
// Each macro expects a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// The consequent must hold in the same cycle as the trigger.
`define ASSERT_IMPLY(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the trigger.
`define ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

### hdl/irst_pkg.sv
// ---------------------------------------------------------------------------
// irst_pkg
// Shared widths, operation codes and sequencer interface types for the
// interrupt request and in-service tracker.
// ---------------------------------------------------------------------------
package irst_pkg;

    localparam int VEC_W   = 8;
    localparam int NUM_VEC = 1 << VEC_W;
    localparam int WORD_W  = 32;
    localparam int BIT_W   = $clog2(WORD_W);
    localparam int N_WORDS = NUM_VEC / WORD_W;
    localparam int IDX_W   = $clog2(N_WORDS);
    localparam int CNT_W   = VEC_W + 1;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_REQ   = 2'd0;
    localparam logic [OP_W-1:0] OP_EOI   = 2'd1;
    localparam logic [OP_W-1:0] OP_WEXIT = 2'd2;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic start;
        logic need_scan;
        logic hit;
        logic out_free;
    } t_seq_sts;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        logic             idle;
        logic             scan;
        logic             done;
        logic [IDX_W-1:0] word_idx;
    } t_seq_ctl;

endpackage

### hdl/irst_prio_enc.sv
// ---------------------------------------------------------------------------
// irst_prio_enc
// Finds the highest set bit of one 32-bit word of a vector set. This is the
// unit shared by every step of a scan.
// ---------------------------------------------------------------------------
module irst_prio_enc
    import irst_pkg::*;
(
    input  logic [WORD_W-1:0] i_word,
    output logic              o_hit,
    output logic [BIT_W-1:0]  o_bit
);

    always_comb begin
        o_hit = |i_word;
        o_bit = '0;
        for (int i = 0; i < WORD_W; i++) begin
            if (i_word[i]) begin
                o_bit = BIT_W'(i);
            end
        end
    end

endmodule

### hdl/irst_ctrl.sv
// ---------------------------------------------------------------------------
// irst_ctrl
// Sequencer: walks the words of a set from the top down, one per cycle,
// until the encoder hits or at word 0, then waits for the output register.
// ---------------------------------------------------------------------------
module irst_ctrl
    import irst_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_seq_sts i_sts,
    output t_seq_ctl o_ctl
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_sts.start) begin
                    if (i_sts.need_scan) begin
                        n_state = S_SCAN;
                        n_idx   = IDX_W'(N_WORDS - 1);
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCAN: begin
                if (i_sts.hit || (r_idx == '0)) begin
                    n_state = S_DONE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    assign o_ctl.idle     = (r_state == S_IDLE);
    assign o_ctl.scan     = (r_state == S_SCAN);
    assign o_ctl.done     = (r_state == S_DONE);
    assign o_ctl.word_idx = r_idx;

endmodule

### hdl/interrupt_request_service_tracker_top.sv
// ---------------------------------------------------------------------------
// interrupt_request_service_tracker_top
// Tracks pending and in-service interrupt vectors and decides injections.
// ---------------------------------------------------------------------------
// Usage: an event is transferred on the input channel when i_valid is high
// and o_stall is low. The block takes one event at a time; o_stall stays high
// from the transfer until the result has been written to the output register.
// A request needs no scan. An end of interrupt or a window exit scans the set
// from the highest 32-bit word down, one word per cycle through a single
// priority encoder, and stops at the first word with a bit set or after the
// lowest word. Then the result is written to the output register, which
// drives o_valid, and the next event can be transferred once it is written.
// Every event yields exactly one result.
// If the receiver holds i_stall high, the result stays in the output register
// and a finished event waits in the sequencer until the register is free.
// Reset clears both vector sets, the pending count, the window exiting flag
// and the output valid; no clearing pass is needed.
// ---------------------------------------------------------------------------
module interrupt_request_service_tracker_top
    import irst_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [OP_W-1:0]  i_operation,
    input  logic [VEC_W-1:0] i_vector,
    input  logic             i_window_open,
    output logic             o_valid,
    input  logic             i_stall,
    output logic             o_inject_valid,
    output logic [VEC_W-1:0] o_inject_vector,
    output logic             o_window_exiting,
    output logic             o_pending_empty
);

    `include "assert_macros.svh"

    t_seq_sts sts;
    t_seq_ctl ctl;

    logic [NUM_VEC-1:0] r_pend, n_pend;
    logic [NUM_VEC-1:0] r_serv, n_serv;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_exit, n_exit;
    logic               n_inj;
    logic [VEC_W-1:0]   n_injv;

    logic [OP_W-1:0]    r_op;
    logic [VEC_W-1:0]   r_vec;
    logic               r_open;
    logic               r_found;
    logic [VEC_W-1:0]   r_found_vec;

    logic               r_out_valid;
    logic               r_out_inj;
    logic [VEC_W-1:0]   r_out_injv;
    logic               r_out_exit;
    logic               r_out_empty;

    logic [WORD_W-1:0]  scan_word;
    logic               enc_hit;
    logic [BIT_W-1:0]   enc_bit;
    logic               accept;
    logic               commit;

    assign accept = i_valid && ctl.idle;
    assign commit = ctl.done && (!r_out_valid || !i_stall);

    assign sts.start     = accept;
    assign sts.need_scan = (i_operation == OP_EOI) || (i_operation == OP_WEXIT);
    assign sts.hit       = enc_hit;
    assign sts.out_free  = !r_out_valid || !i_stall;

    irst_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    // End of interrupt scans the in-service set, a window exit the pending set.
    assign scan_word = (r_op == OP_EOI) ? r_serv[{ctl.word_idx, BIT_W'(0)} +: WORD_W]
                                        : r_pend[{ctl.word_idx, BIT_W'(0)} +: WORD_W];

    irst_prio_enc u_enc (
        .i_word (ctl.scan ? scan_word : '0),
        .o_hit  (enc_hit),
        .o_bit  (enc_bit)
    );

    always_comb begin
        n_pend = r_pend;
        n_serv = r_serv;
        n_cnt  = r_cnt;
        n_exit = r_exit;
        n_inj  = 1'b0;
        n_injv = '0;
        unique case (r_op)
            OP_REQ: begin
                if (r_open) begin
                    if (r_pend[r_vec]) begin
                        n_cnt = r_cnt - 1'b1;
                    end
                    n_pend[r_vec] = 1'b0;
                    n_serv[r_vec] = 1'b1;
                    n_inj         = 1'b1;
                    n_injv        = r_vec;
                end else begin
                    if (!r_pend[r_vec]) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    n_pend[r_vec] = 1'b1;
                    n_exit        = 1'b1;
                end
            end
            OP_EOI: begin
                if (r_found) begin
                    n_serv[r_found_vec] = 1'b0;
                end
            end
            OP_WEXIT: begin
                if (r_found) begin
                    n_pend[r_found_vec] = 1'b0;
                    n_serv[r_found_vec] = 1'b1;
                    n_cnt               = r_cnt - 1'b1;
                    n_inj               = 1'b1;
                    n_injv              = r_found_vec;
                end
                n_exit = (n_cnt != '0);
            end
            default: begin
                // Unused code: state is left alone.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= '0;
            r_serv      <= '0;
            r_cnt       <= '0;
            r_exit      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_found <= 1'b0;
            end else if (ctl.scan && enc_hit) begin
                r_found <= 1'b1;
            end
            if (commit) begin
                r_pend      <= n_pend;
                r_serv      <= n_serv;
                r_cnt       <= n_cnt;
                r_exit      <= n_exit;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op   <= i_operation;
            r_vec  <= i_vector;
            r_open <= i_window_open;
        end
        if (ctl.scan && enc_hit) begin
            r_found_vec <= {ctl.word_idx, enc_bit};
        end
        if (commit) begin
            r_out_inj   <= n_inj;
            r_out_injv  <= n_injv;
            r_out_exit  <= n_exit;
            r_out_empty <= (n_cnt == '0);
        end
    end

    assign o_stall          = !ctl.idle;
    assign o_valid          = r_out_valid;
    assign o_inject_valid   = r_out_inj;
    assign o_inject_vector  = r_out_injv;
    assign o_window_exiting = r_out_exit;
    assign o_pending_empty  = r_out_empty;

    `ASSERT_ALWAYS(a_cnt_matches_set, ((r_cnt == '0) == (r_pend == '0)), "pending count out of step with pending set")
    `ASSERT_IMPLY(a_pending_keeps_exit, (r_cnt != '0), r_exit, "vectors pending with window exiting off")
    `ASSERT_IMPLY(a_no_inject_zero_vec, (o_valid && !o_inject_valid), (o_inject_vector == '0), "vector reported without an injection")
    `ASSERT_NEXT(a_one_at_a_time, (i_valid && !o_stall), o_stall, "second event taken while one is in progress")

endmodule
